FILE: hw/rtl/port_binding_table_defines.svh
// Assertion macros for the port binding table.
// Included by files that carry concurrent assertions; needs nothing else.
`ifndef PORT_BINDING_TABLE_DEFINES_SVH
`define PORT_BINDING_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define PBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/pbt_pkg.sv
// Shared types and codes for the port binding table.
// Used by pbt_cell and port_binding_table; depends on nothing.
package pbt_pkg;

	localparam int MAX_RESULTS = 16;

	localparam logic [2:0] OP_LISTEN   = 3'd0;
	localparam logic [2:0] OP_UNLISTEN = 3'd1;
	localparam logic [2:0] OP_REQUEST  = 3'd2;
	localparam logic [2:0] OP_QUERY    = 3'd3;
	localparam logic [2:0] OP_DISPATCH = 3'd4;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_NONE = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	localparam logic CFG_LOWER = 1'b0;
	localparam logic CFG_UPPER = 1'b1;

	typedef struct packed {
		logic        vld;
		logic [15:0] port;
		logic [7:0]  handler;
	} entry_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_MARK,
		CELL_COMPACT,
		CELL_ROTATE
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t  mode;
		logic [15:0] key;
	} cell_cmd_t;

endpackage

FILE: hw/rtl/port_binding_table.sv
// Top level of the port binding table: command sequencer over a chain of
// binding cells. Depends on pbt_pkg, pbt_cell and port_binding_table_defines.svh.
//
// Channel   Direction  Signals                                    Transfer when
// command   in         start, busy, op, port, handler, start_port start && !busy
// config    in         cfg_we, cfg_index, cfg_wdata               cfg_we
// result    out        done, status, port_found, in_use,          done
//                      handler_out, last
//
// Listen and query each pass through their own state, then register the result; an
// unknown op or a request over an empty port range answers straight from idle. Unlisten
// makes one marking pass, then compacts the chain, one shift per cycle. Request probes
// one port per cycle against all cells, up to ENTRIES+1 probes. Dispatch rotates the
// chain once through cell 0, then gives its final result. Reset empties the table at once.
// Results cannot be stalled; each is shown for a single cycle.
`include "port_binding_table_defines.svh"
module port_binding_table #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [15:0] port,
	input  logic [7:0]  handler,
	input  logic [15:0] start_port,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] port_found,
	output logic        in_use,
	output logic [7:0]  handler_out,
	output logic        last
);

	localparam int CW = $clog2(ENTRIES + 2);
	localparam int MW = $clog2(pbt_pkg::MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LISTEN,
		S_QUERY,
		S_UNMARK,
		S_COMPACT,
		S_REQ,
		S_DISP,
		S_DEND
	} state_t;

	state_t              state_q;
	logic [15:0]         lower_q;
	logic [15:0]         upper_q;
	logic [15:0]         port_q;
	logic [7:0]          handler_q;
	logic [15:0]         cur_q;
	logic [15:0]         first_q;
	logic [CW-1:0]       cnt_q;
	logic [MW-1:0]       mcnt_q;
	logic                hit_q;
	logic                pend_q;
	logic [7:0]          pend_h_q;
	logic                done_q;
	logic [1:0]          status_q;
	logic [15:0]         port_found_q;
	logic                in_use_q;
	logic [7:0]          handler_out_q;
	logic                last_q;

	pbt_pkg::cell_cmd_t  cmd;
	pbt_pkg::entry_t     ents [ENTRIES];
	pbt_pkg::entry_t     head;
	pbt_pkg::entry_t     tail;
	logic [ENTRIES:0]    hole;
	logic [ENTRIES-1:0]  hits;
	logic [ENTRIES-1:0]  vlds;
	logic                any_match;
	logic                full;
	logic                accept;
	logic                range_empty;
	logic [15:0]         start_eff;
	logic [15:0]         cur_next;

	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign any_match   = |hits;
	assign full        = ents[ENTRIES-1].vld;
	assign range_empty = (lower_q > upper_q);
	assign start_eff   = ((start_port < lower_q) || (start_port > upper_q)) ?
		lower_q : start_port;
	assign cur_next    = (cur_q == upper_q) ? lower_q : cur_q + 16'd1;

	assign head    = '{vld: 1'b1, port: port_q, handler: handler_q};
	// The tail takes the head while rotating, and an empty slot otherwise.
	assign tail    = (state_q == S_DISP) ? ents[0] :
		pbt_pkg::entry_t'{vld: 1'b0, port: 16'd0, handler: 8'd0};
	assign hole[0] = 1'b0;

	always_comb begin
		cmd.key = (state_q == S_REQ) ? cur_q : port_q;
		case (state_q)
			S_LISTEN:  cmd.mode = full ? pbt_pkg::CELL_HOLD : pbt_pkg::CELL_PUSH;
			S_UNMARK:  cmd.mode = pbt_pkg::CELL_MARK;
			S_COMPACT: cmd.mode = pbt_pkg::CELL_COMPACT;
			S_DISP:    cmd.mode = pbt_pkg::CELL_ROTATE;
			default:   cmd.mode = pbt_pkg::CELL_HOLD;
		endcase
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		pbt_pkg::entry_t prev_e;
		pbt_pkg::entry_t next_e;
		if (i == 0) begin : g_head
			assign prev_e = head;
		end else begin : g_mid
			assign prev_e = ents[i-1];
		end
		if (i == ENTRIES - 1) begin : g_tail
			assign next_e = tail;
		end else begin : g_body
			assign next_e = ents[i+1];
		end
		pbt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.prev     (prev_e),
			.next     (next_e),
			.hole_in  (hole[i]),
			.hole_out (hole[i+1]),
			.match    (hits[i]),
			.ent      (ents[i])
		);
		assign vlds[i] = ents[i].vld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= 16'd49152;
			upper_q <= 16'd65535;
		end else if (cfg_we) begin
			if (cfg_index == pbt_pkg::CFG_LOWER) begin
				lower_q <= cfg_wdata;
			end else begin
				upper_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			port_q        <= 16'd0;
			handler_q     <= 8'd0;
			cur_q         <= 16'd0;
			first_q       <= 16'd0;
			cnt_q         <= '0;
			mcnt_q        <= '0;
			hit_q         <= 1'b0;
			pend_q        <= 1'b0;
			pend_h_q      <= 8'd0;
			done_q        <= 1'b0;
			status_q      <= pbt_pkg::STAT_OK;
			port_found_q  <= 16'd0;
			in_use_q      <= 1'b0;
			handler_out_q <= 8'd0;
			last_q        <= 1'b0;
		end else begin
			done_q        <= 1'b0;
			status_q      <= pbt_pkg::STAT_OK;
			port_found_q  <= 16'd0;
			in_use_q      <= 1'b0;
			handler_out_q <= 8'd0;
			last_q        <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						port_q    <= port;
						handler_q <= handler;
						cur_q     <= start_eff;
						first_q   <= start_eff;
						cnt_q     <= '0;
						mcnt_q    <= '0;
						pend_q    <= 1'b0;
						case (op)
							pbt_pkg::OP_LISTEN:   state_q <= S_LISTEN;
							pbt_pkg::OP_UNLISTEN: state_q <= S_UNMARK;
							pbt_pkg::OP_QUERY:    state_q <= S_QUERY;
							pbt_pkg::OP_DISPATCH: state_q <= S_DISP;
							pbt_pkg::OP_REQUEST: begin
								if (range_empty) begin
									done_q   <= 1'b1;
									status_q <= pbt_pkg::STAT_NONE;
								end else begin
									state_q <= S_REQ;
								end
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= pbt_pkg::STAT_NONE;
							end
						endcase
					end
				end
				S_LISTEN: begin
					done_q   <= 1'b1;
					status_q <= full ? pbt_pkg::STAT_FULL : pbt_pkg::STAT_OK;
					state_q  <= S_IDLE;
				end
				S_QUERY: begin
					done_q   <= 1'b1;
					in_use_q <= any_match;
					state_q  <= S_IDLE;
				end
				S_UNMARK: begin
					hit_q   <= any_match;
					state_q <= S_COMPACT;
				end
				S_COMPACT: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(ENTRIES - 1)) begin
						done_q   <= 1'b1;
						status_q <= hit_q ? pbt_pkg::STAT_OK : pbt_pkg::STAT_NONE;
						state_q  <= S_IDLE;
					end
				end
				S_REQ: begin
					if (!any_match) begin
						done_q       <= 1'b1;
						port_found_q <= cur_q;
						state_q      <= S_IDLE;
					end else if ((cur_next == first_q) || (cnt_q == CW'(ENTRIES))) begin
						done_q   <= 1'b1;
						status_q <= pbt_pkg::STAT_NONE;
						state_q  <= S_IDLE;
					end else begin
						cur_q <= cur_next;
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_DISP: begin
					// Each match is held back until the next one arrives, so that the final one
					// can be flagged as last.
					if (hits[0] && (mcnt_q != MW'(pbt_pkg::MAX_RESULTS))) begin
						if (pend_q) begin
							done_q        <= 1'b1;
							handler_out_q <= pend_h_q;
							last_q        <= 1'b0;
						end
						pend_q   <= 1'b1;
						pend_h_q <= ents[0].handler;
						mcnt_q   <= mcnt_q + MW'(1);
					end
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(ENTRIES - 1)) begin
						state_q <= S_DEND;
					end
				end
				S_DEND: begin
					done_q        <= 1'b1;
					status_q      <= pend_q ? pbt_pkg::STAT_OK : pbt_pkg::STAT_NONE;
					handler_out_q <= pend_q ? pend_h_q : 8'd0;
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign port_found  = port_found_q;
	assign in_use      = in_use_q;
	assign handler_out = handler_out_q;
	assign last        = last_q;

	`PBT_ASSERT_NXT(a_accept_answers, clk, arst_n, accept, busy || done)
	`PBT_ASSERT_IMP(a_more_follows, clk, arst_n, done && !last, busy)
	`PBT_ASSERT_IMP(a_packed_table, clk, arst_n, state_q == S_IDLE,
		(vlds & (vlds + ENTRIES'(1))) == '0)
	`PBT_ASSERT_IMP(a_full_means_full, clk, arst_n,
		done && (status == pbt_pkg::STAT_FULL), full)

endmodule

FILE: hw/rtl/pbt_cell.sv
// One slot of the binding chain: holds one binding and moves it to or
// from its neighbors. Depends on pbt_pkg.
module pbt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  pbt_pkg::cell_cmd_t cmd,
	input  pbt_pkg::entry_t    prev,
	input  pbt_pkg::entry_t    next,
	input  logic               hole_in,
	output logic               hole_out,
	output logic               match,
	output pbt_pkg::entry_t    ent
);

	logic        vld_q;
	logic [15:0] port_q;
	logic [7:0]  handler_q;
	logic        take_prev;
	logic        take_next;

	assign ent      = '{vld: vld_q, port: port_q, handler: handler_q};
	assign match    = vld_q && (port_q == cmd.key);
	// A slot is a hole if it or any slot nearer the head is empty.
	assign hole_out = hole_in || !vld_q;

	always_comb begin
		take_prev = (cmd.mode == pbt_pkg::CELL_PUSH);
		take_next = (cmd.mode == pbt_pkg::CELL_ROTATE) ||
			((cmd.mode == pbt_pkg::CELL_COMPACT) && hole_out);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take_prev) begin
			vld_q <= prev.vld;
		end else if (take_next) begin
			vld_q <= next.vld;
		end else if (cmd.mode == pbt_pkg::CELL_MARK) begin
			vld_q <= vld_q && !match;
		end
	end

	always_ff @(posedge clk) begin
		if (take_prev) begin
			port_q    <= prev.port;
			handler_q <= prev.handler;
		end else if (take_next) begin
			port_q    <= next.port;
			handler_q <= next.handler;
		end
	end

endmodule
